// ----- sv/lspe_pkg.sv -----
// Package for the line sensor position estimator.
// Holds widths, channel constants, state and control types shared by all modules.
// No dependencies.
package lspe_pkg;

    localparam int NCH       = 6;
    localparam int SAMPLE_W  = 12;
    localparam int Q16_W     = 16;
    localparam int PRE_W     = 16;
    localparam int SCALE_W   = 14;
    localparam int M1_W      = Q16_W + PRE_W;
    localparam int M2_W      = M1_W + SCALE_W;
    localparam int RD_SHIFT  = 20;
    localparam int RD_W      = 24;
    localparam int NUM_W     = 32;
    localparam int MAG_W     = 31;
    localparam int DEN_W     = 27;
    localparam int FRAC_W    = 8;
    localparam int Q_W       = 15;
    localparam int DIV_W     = DEN_W + Q_W - 1;
    localparam int STEP_W    = $clog2(Q_W);
    localparam int POS_W     = 16;
    localparam int ACT_W     = 3;
    localparam int COUNTER_W = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [RD_W-1:0] RD_MAX = {RD_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [1:0] REG_PRESCALER = 2'd0;
    localparam logic [1:0] REG_WHITE     = 2'd1;
    localparam logic [1:0] REG_NO_TRACK  = 2'd2;

    localparam logic [PRE_W-1:0] PRESCALER_RST = 16'd256;
    localparam logic [RD_W-1:0]  WHITE_RST     = 24'd32768;
    localparam logic [POS_W-1:0] NO_TRACK_RST  = 16'd0;

    localparam logic [Q16_W-1:0] BLACK_Q16 [NCH] =
        '{16'd38, 16'd540, 16'd670, 16'd279, 16'd477, 16'd1511};
    localparam logic [SCALE_W-1:0] SCALE_Q12 [NCH] =
        '{14'd14891, 14'd14410, 14'd15468, 14'd13959, 14'd14341, 14'd11544};
    localparam logic signed [5:0] WEIGHT [NCH] =
        '{6'sd27, 6'sd9, -6'sd9, -6'sd27, 6'sd9, -6'sd9};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN,
        ST_MUL1,
        ST_MUL2,
        ST_SAT,
        ST_SUM,
        ST_START,
        ST_WAIT,
        ST_DONE
    } lspe_state_t;

    typedef struct packed {
        logic ld_raw;
        logic ld_min;
        logic ld_mul1;
        logic ld_mul2;
        logic ld_sat;
        logic ld_sum;
    } lspe_ctrl_t;

endpackage

// ----- sv/lspe_lane.sv -----
// One channel lane: noise subtraction, minimum removal, black threshold,
// two-stage gain multiply, saturation and white threshold compare. Uses lspe_pkg.
module lspe_lane
    import lspe_pkg::*;
(
    input  logic                 aclk,
    input  lspe_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0]  lit,
    input  logic [SAMPLE_W-1:0]  dark,
    input  logic [Q16_W-1:0]     mn,
    input  logic [PRE_W-1:0]     prescaler,
    input  logic [RD_W-1:0]      white_level,
    input  logic [Q16_W-1:0]     black,
    input  logic [SCALE_W-1:0]   scale,
    output logic [Q16_W-1:0]     raw,
    output logic [RD_W-1:0]      rd,
    output logic                 active
);

    logic [Q16_W-1:0]          lit_q16;
    logic [Q16_W-1:0]          dark_q16;
    logic [Q16_W-1:0]          v;
    logic [M2_W-RD_SHIFT-1:0]  shifted;
    logic [RD_W-1:0]           rd_sat;

    logic [Q16_W-1:0] raw_reg;
    logic [M1_W-1:0]  m1_reg;
    logic [M2_W-1:0]  m2_reg;
    logic [RD_W-1:0]  rd_reg;
    logic             active_reg;

    assign lit_q16  = {lit, {(Q16_W-SAMPLE_W){1'b0}}};
    assign dark_q16 = {dark, {(Q16_W-SAMPLE_W){1'b0}}};
    assign v        = raw_reg - mn;
    assign shifted  = m2_reg[M2_W-1:RD_SHIFT];
    assign rd_sat   = (|shifted[M2_W-RD_SHIFT-1:RD_W]) ? RD_MAX : shifted[RD_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.ld_raw) begin
            raw_reg <= (lit_q16 > dark_q16) ? (lit_q16 - dark_q16) : '0;
        end
        if (ctrl.ld_mul1) begin
            m1_reg <= (v > black) ? (M1_W'(v) * M1_W'(prescaler)) : '0;
        end
        if (ctrl.ld_mul2) begin
            m2_reg <= M2_W'(m1_reg) * M2_W'(scale);
        end
        if (ctrl.ld_sat) begin
            rd_reg     <= rd_sat;
            active_reg <= rd_sat > white_level;
        end
    end

    assign raw    = raw_reg;
    assign rd     = rd_reg;
    assign active = active_reg;

endmodule

// ----- sv/lspe_merge.sv -----
// Merging stage: scan minimum over the lanes, active count, channel set choice
// and weighted / plain sums for the centroid. Uses lspe_pkg.
module lspe_merge
    import lspe_pkg::*;
(
    input  logic             aclk,
    input  lspe_ctrl_t       ctrl,
    input  logic [Q16_W-1:0] raw [NCH],
    input  logic [RD_W-1:0]  rd [NCH],
    input  logic             active [NCH],
    output logic [Q16_W-1:0] mn,
    output logic [MAG_W-1:0] mag,
    output logic             neg,
    output logic [DEN_W-1:0] den,
    output logic [ACT_W-1:0] active_count
);

    logic [Q16_W-1:0]        min01, min23, min45, min03, min_all;
    logic [ACT_W-1:0]        cnt_c;
    logic                    rear_c;
    logic                    use_all;
    logic signed [NUM_W-1:0] num_c;
    logic [DEN_W-1:0]        den_c;

    logic [Q16_W-1:0] mn_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] den_reg;
    logic [ACT_W-1:0] count_reg;

    // small combinational minimum tree, registered into mn_reg
    assign min01   = (raw[1] < raw[0]) ? raw[1] : raw[0];
    assign min23   = (raw[3] < raw[2]) ? raw[3] : raw[2];
    assign min45   = (raw[5] < raw[4]) ? raw[5] : raw[4];
    assign min03   = (min23 < min01) ? min23 : min01;
    assign min_all = (min45 < min03) ? min45 : min03;

    always_comb begin
        cnt_c = '0;
        for (int i = 0; i < NCH; i++) begin
            cnt_c = cnt_c + ACT_W'(active[i]);
        end
        rear_c  = active[4] | active[5];
        use_all = rear_c || (cnt_c == ACT_W'(1));
        num_c   = '0;
        den_c   = '0;
        for (int i = 0; i < NCH; i++) begin
            if (i < 4 || use_all) begin
                num_c = num_c + NUM_W'($signed(NUM_W'(WEIGHT[i])) * $signed(NUM_W'(rd[i])));
                den_c = den_c + DEN_W'(rd[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_min) begin
            mn_reg <= min_all;
        end
        if (ctrl.ld_sum) begin
            neg_reg   <= num_c[NUM_W-1];
            mag_reg   <= num_c[NUM_W-1] ? MAG_W'(-num_c) : MAG_W'(num_c);
            den_reg   <= den_c;
            count_reg <= cnt_c;
        end
    end

    assign mn           = mn_reg;
    assign mag          = mag_reg;
    assign neg          = neg_reg;
    assign den          = den_reg;
    assign active_count = count_reg;

endmodule

// ----- sv/lspe_div.sv -----
// Restoring divider, one quotient bit per cycle: (mag * 256) / den.
// Quotient always fits Q_W bits since |sum w*r| <= 27 * sum r. Uses lspe_pkg.
module lspe_div
    import lspe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [Q_W-1:0]   quotient
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [Q_W-1:0]    q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(Q_W - 1);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_W'({mag, {FRAC_W{1'b0}}});
            dsh_reg <= {den, {(Q_W-1){1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/line_sensor_position_estimator_unit.sv -----
// Top level of the line sensor position estimator: configuration registers,
// sequencer, six channel lanes, merge stage, divider and result register.
// Depends on lspe_pkg, lspe_lane, lspe_merge, lspe_div.
// Usage:
//   s_ channel: one scan per transaction, twelve 12-bit samples in s_tdata.
//   m_ channel: one result per scan; position, active count and lost-scan
//   count in m_tdata, line found flag in m_tuser.
//   APB port: prescaler at 0x0, white threshold at 0x4, no-track value at 0x8.
//   Write registers only while no scan is in flight.
// Timing:
//   A scan runs through the lanes (noise, minimum, two multiplies,
//   saturation), the merge stage and a 15-step divider before m_tvalid
//   rises. One scan is processed at a time, so a new scan is taken only
//   after the previous result is loaded into the output register; most
//   of that processing is the divider's one-bit-per-cycle loop.
// Reset (aresetn low, synchronous): registers return to their defaults,
//   the lost-scan counter clears and no result is pending.
// Stall: a finished result waits in the output register; the next scan is
//   accepted and processed meanwhile, and holds before its result stage
//   until the output transaction completes.
module line_sensor_position_estimator_unit
    import lspe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // lit_0..lit_5, dark_0..dark_5, 12 bits each, from bit 0 up
    input  logic [2*NCH*SAMPLE_W-1:0] s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // position[15:0], active_count[18:16], no_track_count[34:19], zero fill
    output logic [39:0]           m_tdata,
    // line_found
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    lspe_state_t state_reg, state_next;
    lspe_ctrl_t  ctrl;
    logic        div_start;
    logic        out_load;
    logic        s_accept;
    logic        wr_en;
    logic [1:0]  reg_idx;

    logic [PRE_W-1:0]     prescaler_reg;
    logic [RD_W-1:0]      white_reg;
    logic [POS_W-1:0]     no_track_reg;
    logic [COUNTER_W-1:0] lost_reg;
    logic                 m_valid_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 found_reg;
    logic [ACT_W-1:0]     count_out_reg;

    logic [Q16_W-1:0] raw    [NCH];
    logic [RD_W-1:0]  rd     [NCH];
    logic             active [NCH];
    logic [Q16_W-1:0] mn;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [DEN_W-1:0] den;
    logic [ACT_W-1:0] active_count;
    logic             div_busy;
    logic [Q_W-1:0]   quotient;
    logic             line_found;
    logic [POS_W-1:0] centroid;
    logic [POS_W-1:0] pos_c;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescaler_reg <= PRESCALER_RST;
            white_reg     <= WHITE_RST;
            no_track_reg  <= NO_TRACK_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PRESCALER: prescaler_reg <= pwdata[PRE_W-1:0];
                REG_WHITE:     white_reg     <= pwdata[RD_W-1:0];
                REG_NO_TRACK:  no_track_reg  <= pwdata[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PRESCALER: prdata = DATA_W'(prescaler_reg);
            REG_WHITE:     prdata = DATA_W'(white_reg);
            REG_NO_TRACK:  prdata = DATA_W'(no_track_reg);
            default:       prdata = '0;
        endcase
    end

    // sequencer
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_MIN;
            ST_MIN:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SAT;
            ST_SAT:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (!div_busy) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl         = '0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                ctrl.ld_raw = s_tvalid;
            end
            ST_MIN:   ctrl.ld_min  = 1'b1;
            ST_MUL1:  ctrl.ld_mul1 = 1'b1;
            ST_MUL2:  ctrl.ld_mul2 = 1'b1;
            ST_SAT:   ctrl.ld_sat  = 1'b1;
            ST_SUM:   ctrl.ld_sum  = 1'b1;
            ST_START: div_start    = 1'b1;
            ST_WAIT:  ;
            ST_DONE:  out_load     = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    // lanes
    for (genvar g = 0; g < NCH; g++) begin : g_lane
        lspe_lane u_lane (
            .aclk            (aclk),
            .ctrl            (ctrl),
            .lit             (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .dark            (s_tdata[(NCH+g)*SAMPLE_W +: SAMPLE_W]),
            .mn              (mn),
            .prescaler       (prescaler_reg),
            .white_level     (white_reg),
            .black           (BLACK_Q16[g]),
            .scale           (SCALE_Q12[g]),
            .raw             (raw[g]),
            .rd              (rd[g]),
            .active          (active[g])
        );
    end

    lspe_merge u_merge (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .raw          (raw),
        .rd           (rd),
        .active       (active),
        .mn           (mn),
        .mag          (mag),
        .neg          (neg),
        .den          (den),
        .active_count (active_count)
    );

    lspe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mag      (mag),
        .den      (den),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // result
    assign line_found = active_count != '0;
    assign centroid   = neg ? (POS_W'(0) - POS_W'(quotient)) : POS_W'(quotient);

    always_comb begin
        priority if (!line_found) begin
            pos_c = no_track_reg;
        end else if (den == '0) begin
            pos_c = '0;
        end else begin
            pos_c = centroid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            lost_reg    <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (line_found) begin
                    lost_reg <= '0;
                end else if (lost_reg != {COUNTER_W{1'b1}}) begin
                    lost_reg <= lost_reg + COUNTER_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pos_reg       <= pos_c;
            found_reg     <= line_found;
            count_out_reg <= active_count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {5'b0, lost_reg, count_out_reg, pos_reg};

endmodule
